/* rtl/msds_pkg.sv */
`timescale 1ns / 1ps

package msds_pkg;

  // Duty values in permille
  typedef logic [9:0] duty_t;

  localparam duty_t DUTY_MAX = 10'd1000;

  // One target request between the front, the queue and the back
  typedef struct packed {
    logic  valid;
    duty_t target;
  } tgt_req_t;

endpackage

/* rtl/msds_front.sv */
`timescale 1ns / 1ps

module msds_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [9:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [9:0]         sound_level_i,
  input  logic [31:0]        time_ms_i,
  output msds_pkg::tgt_req_t push_o,
  input  logic               push_stall_i
);
  import msds_pkg::*;

  typedef enum logic [1:0] {
    MODE_MUSIC  = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_ADIV0,
    S_ADIV1,
    S_ADIV2,
    S_MN1,
    S_MN2,
    S_MS0,
    S_MS1,
    S_MS2,
    S_PUSH
  } state_e;

  localparam logic CFG_DRIVE_MODE   = 1'b0;
  localparam logic CFG_MANUAL_SPEED = 1'b1;

  localparam logic [9:0]  NOISE_FLOOR  = 10'd35;
  localparam logic [10:0] LOW_CUT      = 11'd25;
  localparam logic [20:0] NORM_SCALE   = 21'd200;   // 1000/965 == 200/193
  localparam logic [20:0] NORM_DIV     = 21'd193;
  localparam logic [20:0] SHAPE_OFFSET = 21'd650;
  localparam logic [20:0] SHAPE_DIV    = 21'd1650;
  localparam logic [16:0] AUTO_PERIOD  = 17'd8000;
  localparam logic [11:0] AUTO_HALF    = 12'd4000;
  localparam logic [9:0]  AUTO_MIN     = 10'd150;
  localparam logic [9:0]  AUTO_MAX     = 10'd850;
  localparam logic [14:0] SPAN_NUM     = 15'd7;     // 700/4000 == 7/40
  localparam logic [20:0] FIFTH_DIV    = 21'd5;
  // Reciprocals, floor(2^k / divisor) or one below it
  localparam logic [16:0] RECIP_NORM   = 17'd86928; // 2^24 / 193
  localparam logic [16:0] RECIP_SHAPE  = 17'd10167; // floor(2^24 / 1650) - 1
  localparam logic [16:0] RECIP_FIFTH  = 17'd13107; // 2^16 / 5

  state_e      state_q;
  logic [1:0]  mode_q;
  duty_t       speed_q;
  logic [31:0] time_q;
  logic [12:0] rem_q;
  logic [2:0]  cnt_q;
  logic        half_q;
  logic [20:0] x_q;
  logic [37:0] prod_q;
  duty_t       n_q;
  duty_t       tgt_q;

  logic [16:0] mul_k;
  logic [37:0] mul_p;
  logic [16:0] mod_x;
  logic [3:0]  mod_q;
  logic [12:0] mod_r;
  logic [10:0] qn, nn, qs, ss;
  logic [20:0] remn, rems, rema;
  logic [9:0]  qa, qa1;
  logic [11:0] au;
  logic        accept;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign push_o.valid  = (state_q == S_PUSH);
  assign push_o.target = tgt_q;

  // Shared reciprocal multiplier
  always_comb begin
    unique case (state_q)
      S_MN1:   mul_k = RECIP_NORM;
      S_MS1:   mul_k = RECIP_SHAPE;
      default: mul_k = RECIP_FIFTH;
    endcase
  end
  assign mul_p = 38'(x_q) * 38'(mul_k);

  // One nibble of the modulo 8000 reduction, most significant first
  assign mod_x = {rem_q, time_q[31:28]};
  always_comb begin
    mod_q = '0;
    for (int k = 1; k < 16; k++) begin
      if (mod_x >= 17'(k * 8000)) mod_q = mod_q + 4'd1;
    end
    mod_r = 13'(mod_x - 17'(mod_q) * AUTO_PERIOD);
  end

  // Correct reciprocal quotients by one remainder compare
  always_comb begin
    qn   = prod_q[34:24];
    remn = x_q - 21'(qn) * NORM_DIV;
    nn   = qn + 11'(remn >= NORM_DIV);
    qs   = prod_q[34:24];
    rems = x_q - 21'(qs) * SHAPE_DIV;
    ss   = qs + 11'(rems >= SHAPE_DIV);
    qa   = prod_q[25:16];
    rema = x_q - 21'(qa) * FIFTH_DIV;
    qa1  = qa + 10'(rema >= FIFTH_DIV);
    au   = (rem_q >= 13'(AUTO_HALF)) ? 12'(rem_q - 13'(AUTO_HALF)) : rem_q[11:0];
  end

  // Sequencer, configuration and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_MUSIC;
      speed_q <= 10'd300;
      time_q  <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      half_q  <= 1'b0;
      x_q     <= '0;
      prod_q  <= '0;
      n_q     <= '0;
      tgt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DRIVE_MODE:   mode_q  <= cfg_wdata_i[1:0];
          CFG_MANUAL_SPEED: speed_q <= cfg_wdata_i;
          default:          ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (mode_q)
              MODE_MUSIC: begin
                if (sound_level_i <= NOISE_FLOOR) begin
                  tgt_q   <= '0;
                  state_q <= S_PUSH;
                end else begin
                  x_q     <= 21'(sound_level_i - NOISE_FLOOR) * NORM_SCALE;
                  state_q <= S_MN1;
                end
              end
              MODE_MANUAL: begin
                tgt_q   <= (speed_q > DUTY_MAX) ? DUTY_MAX : speed_q;
                state_q <= S_PUSH;
              end
              MODE_AUTO: begin
                time_q  <= time_ms_i;
                rem_q   <= '0;
                cnt_q   <= '0;
                state_q <= S_MOD;
              end
              default: begin
                tgt_q   <= '0;
                state_q <= S_PUSH;
              end
            endcase
          end
        end
        // Auto: time modulo 8000, then triangle
        S_MOD: begin
          rem_q  <= mod_r;
          time_q <= {time_q[27:0], 4'd0};
          cnt_q  <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) state_q <= S_ADIV0;
        end
        S_ADIV0: begin
          half_q  <= (rem_q >= 13'(AUTO_HALF));
          x_q     <= 21'((15'(au) * SPAN_NUM) >> 3);
          state_q <= S_ADIV1;
        end
        S_ADIV1: begin
          prod_q  <= mul_p;
          state_q <= S_ADIV2;
        end
        S_ADIV2: begin
          tgt_q   <= half_q ? AUTO_MAX - qa1 : AUTO_MIN + qa1;
          state_q <= S_PUSH;
        end
        // Music: normalize, shape, cut
        S_MN1: begin
          prod_q  <= mul_p;
          state_q <= S_MN2;
        end
        S_MN2: begin
          n_q     <= (nn > 11'(DUTY_MAX)) ? DUTY_MAX : nn[9:0];
          state_q <= S_MS0;
        end
        S_MS0: begin
          x_q     <= 21'(n_q) * (SHAPE_OFFSET + 21'(n_q));
          state_q <= S_MS1;
        end
        S_MS1: begin
          prod_q  <= mul_p;
          state_q <= S_MS2;
        end
        S_MS2: begin
          if (ss < LOW_CUT)               tgt_q <= '0;
          else if (ss > 11'(DUTY_MAX))    tgt_q <= DUTY_MAX;
          else                            tgt_q <= ss[9:0];
          state_q <= S_PUSH;
        end
        // Hand the target to the queue
        S_PUSH: begin
          if (!push_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_push_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> push_o.target <= DUTY_MAX)
    else $error("target request above full duty");

  a_push_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid && push_stall_i |=> push_o.valid && $stable(push_o.target))
    else $error("stalled target request changed");

  a_auto_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_q == MODE_AUTO) |=> (state_q == S_MOD) && (cnt_q == 3'd0))
    else $error("auto request did not start the modulo sweep");

endmodule

/* rtl/msds_queue.sv */
`timescale 1ns / 1ps

module msds_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msds_pkg::tgt_req_t push_i,
  output logic               push_stall_o,
  output msds_pkg::tgt_req_t pop_o,
  input  logic               pop_stall_i
);
  import msds_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  duty_t             entry_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign push_stall_o  = (count_q == CNT_W'(DEPTH));
  assign pop_o.valid   = (count_q != '0);
  assign pop_o.target  = entry_q[rd_ptr_q];
  assign do_push       = push_i.valid && !push_stall_o;
  assign do_pop        = pop_o.valid && !pop_stall_i;

  // Store the pushed target
  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_i.target;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("push without pop did not raise fill count");

  a_pop_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o.valid && pop_stall_i |=> pop_o.valid && $stable(pop_o.target))
    else $error("stalled queue head changed");

endmodule

/* rtl/msds_back.sv */
`timescale 1ns / 1ps

module msds_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msds_pkg::tgt_req_t pop_i,
  output logic               pop_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output msds_pkg::duty_t    applied_duty_o,
  output msds_pkg::duty_t    target_duty_o
);
  import msds_pkg::*;

  localparam logic [10:0] UP_CAP   = 11'd80;
  localparam logic [10:0] DOWN_CAP = 11'd35;

  duty_t       duty_q;
  logic        out_valid_q;
  duty_t       applied_q;
  duty_t       target_q;
  logic        load;
  duty_t       gap;
  logic [10:0] up_step, dn_step;
  duty_t       duty_d;

  assign pop_stall_o    = out_valid_q && out_stall_i;
  assign load           = pop_i.valid && !pop_stall_o;
  assign out_valid_o    = out_valid_q;
  assign applied_duty_o = applied_q;
  assign target_duty_o  = target_q;

  // Slew to target: up gap/4 (cap 80), down gap/8 (cap 35), rounded up
  always_comb begin
    gap     = (pop_i.target > duty_q) ? pop_i.target - duty_q : duty_q - pop_i.target;
    up_step = (11'(gap) + 11'd3) >> 2;
    dn_step = (11'(gap) + 11'd7) >> 3;
    if (up_step > UP_CAP) up_step = UP_CAP;
    if (dn_step > DOWN_CAP) dn_step = DOWN_CAP;
    if (pop_i.target > duty_q)      duty_d = duty_q + up_step[9:0];
    else if (pop_i.target < duty_q) duty_d = duty_q - dn_step[9:0];
    else                            duty_d = duty_q;
  end

  // Hold duty state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        duty_q      <= duty_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      applied_q <= duty_d;
      target_q  <= pop_i.target;
    end
  end

  a_duty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_q == applied_duty_o)
    else $error("duty state differs from shown result");

  a_rise_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (pop_i.target > duty_q) |=>
      (applied_duty_o > $past(duty_q)) && (applied_duty_o <= $past(pop_i.target)))
    else $error("rising duty left the range toward its target");

  a_fall_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (pop_i.target < duty_q) |=>
      (applied_duty_o < $past(duty_q)) && (applied_duty_o >= $past(pop_i.target)))
    else $error("falling duty left the range toward its target");

endmodule

/* rtl/mode_select_motor_duty_slew.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o   sound_level_i, time_ms_i
// out      output     out_valid_o / out_stall_i applied_duty_o, target_duty_o
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// The front sequencer takes one request at a time. Manual mode, unused mode and music
// below the noise floor go straight to the push step; music mode first normalizes and
// shapes; auto runs eight nibble steps of the modulo 8000 reduction, then the divide.
// All modes end in the push step. The slew back end retires one target per cycle
// while the output is not stalled. Reset clears the duty to 0, mode to music, manual
// speed to 300. An output stall fills the target queue and then stalls the front.

module mode_select_motor_duty_slew #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [9:0]             cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [9:0]             sound_level_i,
  input  logic [31:0]            time_ms_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [9:0]             applied_duty_o,
  output logic [9:0]             target_duty_o
);
  import msds_pkg::*;

  tgt_req_t push_req, pop_req;
  logic     push_stall, pop_stall;

  msds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sound_level_i(sound_level_i),
    .time_ms_i    (time_ms_i),
    .push_o       (push_req),
    .push_stall_i (push_stall)
  );

  msds_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_req),
    .push_stall_o(push_stall),
    .pop_o       (pop_req),
    .pop_stall_i (pop_stall)
  );

  msds_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_i         (pop_req),
    .pop_stall_o   (pop_stall),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .applied_duty_o(applied_duty_o),
    .target_duty_o (target_duty_o)
  );

endmodule
